// ===== src/lms_pkg.sv =====
// Package for the uniform Laplacian mesh smoothing block.
// Holds store sizes, field widths and the operation and status codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package lms_pkg;
   localparam int MAX_VERTICES  = 1024;
   localparam int MAX_TRIANGLES = 2048;
   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
   localparam int TIDX_W = $clog2(MAX_TRIANGLES);
   localparam int TCNT_W = $clog2(MAX_TRIANGLES + 1);
   localparam int COORD_W = 32;
   localparam int DEG_W = $clog2(6 * MAX_TRIANGLES + 1);
   localparam int SUM_W = COORD_W + DEG_W + 1;
   localparam int QUO_W = COORD_W + 1;
   localparam int GAIN_W = 17;
   localparam int ITER_W = 8;

   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

   localparam logic [2:0] OP_CLEAR         = 3'd0;
   localparam logic [2:0] OP_LOAD_VERTEX   = 3'd1;
   localparam logic [2:0] OP_LOAD_TRIANGLE = 3'd2;
   localparam logic [2:0] OP_RUN           = 3'd3;
   localparam logic [2:0] OP_READ          = 3'd4;

   localparam logic [1:0] ST_READ_OK    = 2'd0;
   localparam logic [1:0] ST_RUN_DONE   = 2'd1;
   localparam logic [1:0] ST_READ_RANGE = 2'd2;

   localparam logic CSR_ITERATIONS = 1'b0;
   localparam logic CSR_GAIN       = 1'b1;
endpackage

// ===== src/lms_div.sv =====
// Bit-serial divider: signed neighbour sum over unsigned degree, truncated
// toward zero. Depends on lms_pkg for the sum, degree and quotient widths.
`timescale 1ns / 1ps
module lms_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [lms_pkg::SUM_W-1:0]    dividend,
   input  logic        [lms_pkg::DEG_W-1:0]    divisor,
   output logic                                done,
   output logic signed [lms_pkg::QUO_W-1:0]    quotient
);
   import lms_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [DEG_W:0]   rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             neg_ff, neg_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEG_W:0]   rem_shift;
   logic [SUM_W-1:0] mag_signed;

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_shift = {rem_ff[DEG_W-1:0], quo_ff[SUM_W-1]};
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
         neg_in   = dividend[SUM_W-1];
         count_in = CNT_W'(SUM_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, divisor}) begin
            rem_in = rem_shift - {1'b0, divisor};
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   assign mag_signed = neg_ff ? SUM_W'(-quo_ff) : quo_ff;
   assign quotient   = QUO_W'(mag_signed);
   assign done       = done_ff;
endmodule

// ===== src/uniform_laplacian_mesh_smooth.sv =====
// Uniform Laplacian mesh smoothing engine: vertex, triangle and neighbour
// stores, the pass sequencer and the response register. Depends on lms_pkg
// and instantiates the divider lms_div.
//
// A vertex read registers the stored vertex and then the response register;
// an out-of-range read answers from the response register alone. Each pass
// of a run clears the neighbour sums vertex by vertex, walks every triangle
// with one read-modify-write of a neighbour entry per half edge, and then
// divides each axis of every vertex that has neighbours on the single
// bit-serial divider shared by the three axes. The block takes no new
// transfer while a run or a read is in progress or a response is waiting.
`timescale 1ns / 1ps
module uniform_laplacian_mesh_smooth (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [lms_pkg::GAIN_W-1:0]        csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_op,
   input  logic signed [lms_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [lms_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [lms_pkg::COORD_W-1:0] req_pos_z,
   input  logic [lms_pkg::VIDX_W-1:0]        req_corner_a,
   input  logic [lms_pkg::VIDX_W-1:0]        req_corner_b,
   input  logic [lms_pkg::VIDX_W-1:0]        req_corner_c,
   input  logic [lms_pkg::VIDX_W-1:0]        req_read_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [lms_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [lms_pkg::COORD_W-1:0] rsp_out_y,
   output logic signed [lms_pkg::COORD_W-1:0] rsp_out_z,
   output logic [1:0]                        rsp_status
);
   import lms_pkg::*;

   localparam int PROD_W = QUO_W + 1 + GAIN_W + 1;
   localparam int RES_W  = PROD_W - 16 + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CLR, S_TRI_RD, S_TRI_LAT, S_EDGE_RD, S_EDGE_WR,
      S_UPD_RD, S_UPD_LAT, S_DIV_START, S_DIV_WAIT, S_MUL, S_UPD_WR
   } state_type;

   state_type state_ff;
   logic [ITER_W-1:0]  iterations_ff, iter_ff;
   logic [GAIN_W-1:0]  gain_ff, gain_eff;
   logic [VCNT_W-1:0]  vcount_ff, idx_ff;
   logic [TCNT_W-1:0]  tcount_ff, tidx_ff;
   logic [2:0]         edge_ff;
   logic [1:0]         axis_ff;
   logic [VIDX_W-1:0]  ca_ff, cb_ff, cc_ff;
   logic signed [COORD_W-1:0] p_ff [3];
   logic signed [SUM_W-1:0]   s_ff [3];
   logic [DEG_W-1:0]   deg_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic               rsp_valid_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [1:0]         rsp_status_ff;

   logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
   logic signed [COORD_W-1:0] mem_z [MAX_VERTICES];
   logic [3*VIDX_W-1:0]       mem_t [MAX_TRIANGLES];
   logic signed [SUM_W-1:0]   mem_sx [MAX_VERTICES];
   logic signed [SUM_W-1:0]   mem_sy [MAX_VERTICES];
   logic signed [SUM_W-1:0]   mem_sz [MAX_VERTICES];
   logic [DEG_W-1:0]          mem_d [MAX_VERTICES];

   logic signed [COORD_W-1:0] cq_x, cq_y, cq_z;
   logic [3*VIDX_W-1:0]       tq;
   logic signed [SUM_W-1:0]   sq_x, sq_y, sq_z;
   logic [DEG_W-1:0]          dq;

   logic               c_we_x, c_we_y, c_we_z;
   logic [VIDX_W-1:0]  c_waddr, c_raddr;
   logic signed [COORD_W-1:0] c_wd_x, c_wd_y, c_wd_z;
   logic               t_we;
   logic               s_we;
   logic [VIDX_W-1:0]  s_addr;
   logic signed [SUM_W-1:0] s_wd_x, s_wd_y, s_wd_z;
   logic [DEG_W-1:0]   d_wd;
   logic [VIDX_W-1:0]  dst, src;

   logic               accept;
   logic               div_start, div_done;
   logic signed [QUO_W-1:0]   quotient;
   logic signed [QUO_W:0]     diff;
   logic signed [RES_W-1:0]   res_wide;
   logic signed [COORD_W-1:0] res_sat;
   logic               tri_ok, last_vertex;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign gain_eff  = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;
   assign tri_ok    = (tcount_ff < TCNT_W'(MAX_TRIANGLES))
                      && ({1'b0, req_corner_a} < vcount_ff)
                      && ({1'b0, req_corner_b} < vcount_ff)
                      && ({1'b0, req_corner_c} < vcount_ff);
   assign last_vertex = (idx_ff == vcount_ff - 1'b1);

   always_comb begin
      case (edge_ff)
         3'd0:    begin dst = ca_ff; src = cb_ff; end
         3'd1:    begin dst = cb_ff; src = ca_ff; end
         3'd2:    begin dst = cb_ff; src = cc_ff; end
         3'd3:    begin dst = cc_ff; src = cb_ff; end
         3'd4:    begin dst = cc_ff; src = ca_ff; end
         3'd5:    begin dst = ca_ff; src = cc_ff; end
         default: begin dst = ca_ff; src = cb_ff; end
      endcase
   end

   assign diff     = quotient - (QUO_W+1)'(p_ff[axis_ff]);
   assign res_wide = RES_W'(p_ff[axis_ff]) + RES_W'($signed(prod_ff[PROD_W-1:16]));
   always_comb begin
      if (res_wide > RES_W'(32'sh7fffffff)) begin
         res_sat = 32'sh7fffffff;
      end else if (res_wide < -RES_W'(33'sh080000000)) begin
         res_sat = 32'sh80000000;
      end else begin
         res_sat = COORD_W'(res_wide);
      end
   end

   always_comb begin
      c_we_x = 1'b0;
      c_we_y = 1'b0;
      c_we_z = 1'b0;
      c_waddr = vcount_ff[VIDX_W-1:0];
      c_wd_x = req_pos_x;
      c_wd_y = req_pos_y;
      c_wd_z = req_pos_z;
      t_we = 1'b0;
      s_we = 1'b0;
      s_addr = idx_ff[VIDX_W-1:0];
      s_wd_x = '0;
      s_wd_y = '0;
      s_wd_z = '0;
      d_wd = '0;
      c_raddr = idx_ff[VIDX_W-1:0];
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            c_raddr = req_read_index;
            if (accept && req_op == OP_LOAD_VERTEX
                && vcount_ff < VCNT_W'(MAX_VERTICES)) begin
               c_we_x = 1'b1;
               c_we_y = 1'b1;
               c_we_z = 1'b1;
            end
            t_we = accept && req_op == OP_LOAD_TRIANGLE && tri_ok;
         end
         S_CLR: begin
            s_we = 1'b1;
         end
         S_EDGE_RD: begin
            s_addr  = dst;
            c_raddr = src;
         end
         S_EDGE_WR: begin
            s_addr  = dst;
            c_raddr = src;
            s_we    = 1'b1;
            s_wd_x  = sq_x + SUM_W'(cq_x);
            s_wd_y  = sq_y + SUM_W'(cq_y);
            s_wd_z  = sq_z + SUM_W'(cq_z);
            d_wd    = dq + 1'b1;
         end
         S_DIV_START: begin
            div_start = 1'b1;
         end
         S_UPD_WR: begin
            c_waddr = idx_ff[VIDX_W-1:0];
            c_wd_x  = res_sat;
            c_wd_y  = res_sat;
            c_wd_z  = res_sat;
            c_we_x  = (axis_ff == 2'd0);
            c_we_y  = (axis_ff == 2'd1);
            c_we_z  = (axis_ff == 2'd2);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (c_we_x) mem_x[c_waddr] <= c_wd_x;
      if (c_we_y) mem_y[c_waddr] <= c_wd_y;
      if (c_we_z) mem_z[c_waddr] <= c_wd_z;
      cq_x <= mem_x[c_raddr];
      cq_y <= mem_y[c_raddr];
      cq_z <= mem_z[c_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we) mem_t[tcount_ff[TIDX_W-1:0]] <= {req_corner_a, req_corner_b, req_corner_c};
      tq <= mem_t[tidx_ff[TIDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         mem_sx[s_addr] <= s_wd_x;
         mem_sy[s_addr] <= s_wd_y;
         mem_sz[s_addr] <= s_wd_z;
         mem_d[s_addr]  <= d_wd;
      end
      sq_x <= mem_sx[s_addr];
      sq_y <= mem_sy[s_addr];
      sq_z <= mem_sz[s_addr];
      dq   <= mem_d[s_addr];
   end

   lms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (s_ff[axis_ff]),
      .divisor  (deg_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         iterations_ff <= '0;
         gain_ff       <= '0;
         vcount_ff     <= '0;
         tcount_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ITERATIONS: iterations_ff <= csr_wdata[ITER_W-1:0];
               CSR_GAIN:       gain_ff       <= csr_wdata;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_op == OP_CLEAR) begin
                     vcount_ff <= '0;
                     tcount_ff <= '0;
                  end else if (req_op == OP_LOAD_VERTEX) begin
                     if (vcount_ff < VCNT_W'(MAX_VERTICES)) vcount_ff <= vcount_ff + 1'b1;
                  end else if (req_op == OP_LOAD_TRIANGLE) begin
                     if (tri_ok) tcount_ff <= tcount_ff + 1'b1;
                  end else if (req_op == OP_RUN) begin
                     if (vcount_ff == '0 || iterations_ff == '0 || gain_eff == '0) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= ST_RUN_DONE;
                        rsp_x_ff <= '0;
                        rsp_y_ff <= '0;
                        rsp_z_ff <= '0;
                     end else begin
                        iter_ff  <= iterations_ff;
                        idx_ff   <= '0;
                        state_ff <= S_CLR;
                     end
                  end else if (req_op == OP_READ) begin
                     if ({1'b0, req_read_index} < vcount_ff) begin
                        state_ff <= S_READ;
                     end else begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= ST_READ_RANGE;
                        rsp_x_ff <= '0;
                        rsp_y_ff <= '0;
                        rsp_z_ff <= '0;
                     end
                  end
               end
            end
            S_READ: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= ST_READ_OK;
               rsp_x_ff <= cq_x;
               rsp_y_ff <= cq_y;
               rsp_z_ff <= cq_z;
               state_ff <= S_IDLE;
            end
            S_CLR: begin
               if (last_vertex) begin
                  idx_ff  <= '0;
                  tidx_ff <= '0;
                  state_ff <= (tcount_ff == '0) ? S_UPD_RD : S_TRI_RD;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_TRI_RD: begin
               state_ff <= S_TRI_LAT;
            end
            S_TRI_LAT: begin
               ca_ff   <= tq[3*VIDX_W-1:2*VIDX_W];
               cb_ff   <= tq[2*VIDX_W-1:VIDX_W];
               cc_ff   <= tq[VIDX_W-1:0];
               edge_ff <= '0;
               state_ff <= S_EDGE_RD;
            end
            S_EDGE_RD: begin
               state_ff <= S_EDGE_WR;
            end
            S_EDGE_WR: begin
               if (edge_ff != 3'd5) begin
                  edge_ff  <= edge_ff + 1'b1;
                  state_ff <= S_EDGE_RD;
               end else if (tidx_ff == tcount_ff - 1'b1) begin
                  state_ff <= S_UPD_RD;
               end else begin
                  tidx_ff  <= tidx_ff + 1'b1;
                  state_ff <= S_TRI_RD;
               end
            end
            S_UPD_RD: begin
               state_ff <= S_UPD_LAT;
            end
            S_UPD_LAT: begin
               p_ff[0] <= cq_x;
               p_ff[1] <= cq_y;
               p_ff[2] <= cq_z;
               s_ff[0] <= sq_x;
               s_ff[1] <= sq_y;
               s_ff[2] <= sq_z;
               deg_ff  <= dq;
               axis_ff <= 2'd0;
               if (dq != '0) begin
                  state_ff <= S_DIV_START;
               end else if (!last_vertex) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_UPD_RD;
               end else if (iter_ff == ITER_W'(1)) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_RUN_DONE;
                  rsp_x_ff <= '0;
                  rsp_y_ff <= '0;
                  rsp_z_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  iter_ff  <= iter_ff - 1'b1;
                  idx_ff   <= '0;
                  state_ff <= S_CLR;
               end
            end
            S_DIV_START: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= diff * $signed({1'b0, gain_eff});
               state_ff <= S_UPD_WR;
            end
            S_UPD_WR: begin
               if (axis_ff != 2'd2) begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= S_DIV_START;
               end else if (!last_vertex) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_UPD_RD;
               end else if (iter_ff == ITER_W'(1)) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_RUN_DONE;
                  rsp_x_ff <= '0;
                  rsp_y_ff <= '0;
                  rsp_z_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  iter_ff  <= iter_ff - 1'b1;
                  idx_ff   <= '0;
                  state_ff <= S_CLR;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = rsp_x_ff;
   assign rsp_out_y  = rsp_y_ff;
   assign rsp_out_z  = rsp_z_ff;
   assign rsp_status = rsp_status_ff;
endmodule

// ===== src/lms_check.sv =====
// Port-level checker for the mesh smoothing block and its bind statement.
// Depends on lms_pkg for the operation and status codes.
`timescale 1ns / 1ps
module lms_check (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [2:0]                         req_op,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [lms_pkg::COORD_W-1:0] rsp_out_x,
   input logic signed [lms_pkg::COORD_W-1:0] rsp_out_y,
   input logic signed [lms_pkg::COORD_W-1:0] rsp_out_z,
   input logic [1:0]                         rsp_status
);
   import lms_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_x))
      else $error("Stalled response changed.");

   a_run_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_RUN_DONE || rsp_status == ST_READ_RANGE)
      |-> rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0)
      else $error("Status-only response carries coordinates.");

   a_busy_after_answering_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_RUN || req_op == OP_READ) |=> req_stall)
      else $error("New transfer taken before a run or read was answered.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("Unknown response status.");
endmodule

bind uniform_laplacian_mesh_smooth lms_check u_lms_check (.*);
